// File: rtl/core/rmth_pkg.sv
// ----------------------------------------------------------------------------
// rmth_pkg: shared types and defaults for the running median core
// Sequencer states and default sizing constants.
// ----------------------------------------------------------------------------
package rmth_pkg;

	localparam int MAX_ITEMS_DEF    = 1024;
	localparam int SAMPLE_WIDTH_DEF = 16;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SU_RD,
		S_SU_CMP,
		S_SD_RDL,
		S_SD_RDR,
		S_SD_CMPR,
		S_FIN
	} rmth_state_t;

endpackage

// File: rtl/core/rmth_ram.sv
// ----------------------------------------------------------------------------
// rmth_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rmth_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 513
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/running_median_two_heaps_core.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps_core: running median over a signed sample stream
// Lower half in a max-heap, upper half in a min-heap, both in RAM; one shared
// comparator walks the heaps under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel | valid     | stall      | payload
//  --------+-----------+------------+------------------
//  input   | in_valid  | in_stall   | sample, restart
//  output  | out_valid | out_stall  | median, overflow
//
//  One beat in, one beat out. An item is taken in, then the heaps are walked:
//  sift-up reads the parent, then compares, per level; sift-down reads both
//  children through the single RAM read port, one compare each, per level.
//  A full-store drop skips the heap walks and goes straight to the result.
//  in_stall is high whenever the sequencer is busy. A finished result waits
//  in the output register; the next input beat is taken meanwhile, and the
//  sequencer holds in its final state only if that register is still full.
//  Reset clears counts, median and control; heap RAM is never cleared since
//  only entries below a heap's count are read.
// ----------------------------------------------------------------------------
module running_median_two_heaps_core #(
	parameter int MAX_ITEMS    = rmth_pkg::MAX_ITEMS_DEF,
	parameter int SAMPLE_WIDTH = rmth_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] median,
	output logic                           overflow
);

	localparam int W  = SAMPLE_WIDTH;
	localparam int HD = MAX_ITEMS / 2 + 1;   // entries per heap
	localparam int AW = $clog2(HD);
	localparam int CW = $clog2(HD + 1);
	localparam logic [CW:0] MAXV = (CW + 1)'(MAX_ITEMS);

	rmth_pkg::rmth_state_t state_q, state_d;

	logic signed [W-1:0] v_q, v_d;        // value being placed
	logic signed [W-1:0] pv_q, pv_d;      // top moved to the other heap
	logic signed [W-1:0] bval_q, bval_d;  // best of value and left child
	logic [CW-1:0] i_q, i_d;              // current slot
	logic [CW-1:0] p_q, p_d;              // parent slot
	logic [CW-1:0] n_q, n_d;              // heap size during sift-down
	logic sel_q, sel_d;                   // 0 = low (max) heap, 1 = high (min)
	logic best_l_q, best_l_d;
	logic r_ok_q, r_ok_d;
	logic ovf_q, ovf_d;
	logic [CW-1:0] lo_cnt_q, lo_cnt_d, hi_cnt_q, hi_cnt_d;
	logic signed [W-1:0] cur_med_q, cur_med_d;
	logic signed [W-1:0] top_lo_q, top_lo_d, top_hi_q, top_hi_d;
	logic out_valid_q, out_valid_d, overflow_q, overflow_d;
	logic signed [W-1:0] median_q, median_d;

	// RAM and shared comparator
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic signed [W-1:0] wdata;
	logic signed [W-1:0] rd_lo, rd_hi, rd;
	logic signed [W-1:0] cmp_a, cmp_b;
	logic          ranks;

	logic [CW:0] l_idx, r_idx, total;
	logic signed [W:0] sum, sum_adj;
	logic signed [W-1:0] mean, new_med;

	rmth_ram #(.WIDTH(W), .DEPTH(HD)) u_low (
		.clk(clk), .we(we && !sel_q), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rd_lo)
	);

	rmth_ram #(.WIDTH(W), .DEPTH(HD)) u_high (
		.clk(clk), .we(we && sel_q), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rd_hi)
	);

	assign rd = sel_q ? rd_hi : rd_lo;

	// max-heap ranks larger higher, min-heap smaller
	assign ranks = sel_q ? (cmp_a < cmp_b) : (cmp_a > cmp_b);

	assign l_idx = {i_q, 1'b1};
	assign r_idx = l_idx + 1'b1;
	assign total = {1'b0, lo_cnt_q} + {1'b0, hi_cnt_q};

	// mean of tops, truncated toward zero
	assign sum     = {top_lo_q[W-1], top_lo_q} + {top_hi_q[W-1], top_hi_q};
	assign sum_adj = sum + {{W{1'b0}}, sum[W]};
	assign mean    = sum_adj[W:1];
	assign new_med = (lo_cnt_q > hi_cnt_q) ? top_lo_q :
	                 (hi_cnt_q > lo_cnt_q) ? top_hi_q : mean;

	assign in_stall  = (state_q != rmth_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign median    = median_q;
	assign overflow  = overflow_q;

	always_comb begin
		state_d     = state_q;
		v_d         = v_q;
		pv_d        = pv_q;
		bval_d      = bval_q;
		i_d         = i_q;
		p_d         = p_q;
		n_d         = n_q;
		sel_d       = sel_q;
		best_l_d    = best_l_q;
		r_ok_d      = r_ok_q;
		ovf_d       = ovf_q;
		lo_cnt_d    = lo_cnt_q;
		hi_cnt_d    = hi_cnt_q;
		cur_med_d   = cur_med_q;
		out_valid_d = out_valid_q;
		overflow_d  = overflow_q;
		median_d    = median_q;
		we          = 1'b0;
		waddr       = i_q[AW-1:0];
		wdata       = v_q;
		raddr       = '0;
		cmp_a       = v_q;
		cmp_b       = rd;

		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			rmth_pkg::S_IDLE: begin
				if (in_valid) begin
					v_d    = sample;
					ovf_d  = 1'b0;
					if (restart) begin
						sel_d    = 1'b0;
						i_d      = '0;
						lo_cnt_d = CW'(1);
						hi_cnt_d = '0;
						state_d  = rmth_pkg::S_SU_RD;
					end else if (total >= MAXV) begin
						ovf_d   = 1'b1;
						state_d = rmth_pkg::S_FIN;
					end else if (lo_cnt_q > hi_cnt_q && sample < cur_med_q) begin
						// low top crosses over, sample replaces it
						sel_d   = 1'b0;
						i_d     = '0;
						n_d     = lo_cnt_q;
						pv_d    = top_lo_q;
						state_d = rmth_pkg::S_SD_RDL;
					end else if (hi_cnt_q > lo_cnt_q && sample > cur_med_q) begin
						sel_d   = 1'b1;
						i_d     = '0;
						n_d     = hi_cnt_q;
						pv_d    = top_hi_q;
						state_d = rmth_pkg::S_SD_RDL;
					end else if (hi_cnt_q > lo_cnt_q ||
					             (lo_cnt_q == hi_cnt_q && sample < cur_med_q)) begin
						sel_d    = 1'b0;
						i_d      = lo_cnt_q;
						lo_cnt_d = lo_cnt_q + 1'b1;
						state_d  = rmth_pkg::S_SU_RD;
					end else begin
						sel_d    = 1'b1;
						i_d      = hi_cnt_q;
						hi_cnt_d = hi_cnt_q + 1'b1;
						state_d  = rmth_pkg::S_SU_RD;
					end
				end
			end

			rmth_pkg::S_SU_RD: begin
				if (i_q == '0) begin
					we      = 1'b1;
					state_d = rmth_pkg::S_FIN;
				end else begin
					p_d     = (i_q - 1'b1) >> 1;
					raddr   = p_d[AW-1:0];
					state_d = rmth_pkg::S_SU_CMP;
				end
			end

			rmth_pkg::S_SU_CMP: begin
				we = 1'b1;
				if (ranks) begin
					wdata   = rd;
					i_d     = p_q;
					state_d = rmth_pkg::S_SU_RD;
				end else begin
					state_d = rmth_pkg::S_FIN;
				end
			end

			rmth_pkg::S_SD_RDL: begin
				if (l_idx >= {1'b0, n_q}) begin
					we = 1'b1;
					// sift-down done: carry the old top across
					sel_d  = !sel_q;
					v_d    = pv_q;
					if (sel_q) begin
						i_d      = lo_cnt_q;
						lo_cnt_d = lo_cnt_q + 1'b1;
					end else begin
						i_d      = hi_cnt_q;
						hi_cnt_d = hi_cnt_q + 1'b1;
					end
					state_d = rmth_pkg::S_SU_RD;
				end else begin
					raddr   = l_idx[AW-1:0];
					r_ok_d  = (r_idx < {1'b0, n_q});
					state_d = rmth_pkg::S_SD_RDR;
				end
			end

			rmth_pkg::S_SD_RDR: begin
				cmp_a    = rd;
				cmp_b    = v_q;
				best_l_d = ranks;
				bval_d   = ranks ? rd : v_q;
				raddr    = r_idx[AW-1:0];
				state_d  = rmth_pkg::S_SD_CMPR;
			end

			rmth_pkg::S_SD_CMPR: begin
				cmp_a = rd;
				cmp_b = bval_q;
				we    = 1'b1;
				if (r_ok_q && ranks) begin
					wdata   = rd;
					i_d     = r_idx[CW-1:0];
					state_d = rmth_pkg::S_SD_RDL;
				end else if (best_l_q) begin
					wdata   = bval_q;
					i_d     = l_idx[CW-1:0];
					state_d = rmth_pkg::S_SD_RDL;
				end else begin
					sel_d  = !sel_q;
					v_d    = pv_q;
					if (sel_q) begin
						i_d      = lo_cnt_q;
						lo_cnt_d = lo_cnt_q + 1'b1;
					end else begin
						i_d      = hi_cnt_q;
						hi_cnt_d = hi_cnt_q + 1'b1;
					end
					state_d = rmth_pkg::S_SU_RD;
				end
			end

			rmth_pkg::S_FIN: begin
				if (!(out_valid_q && out_stall)) begin
					out_valid_d = 1'b1;
					overflow_d  = ovf_q;
					median_d    = ovf_q ? cur_med_q : new_med;
					cur_med_d   = median_d;
					state_d     = rmth_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = rmth_pkg::S_IDLE;
			end
		endcase

		// keep copies of both heap tops
		top_lo_d = top_lo_q;
		top_hi_d = top_hi_q;
		if (we && waddr == '0) begin
			if (sel_q) begin
				top_hi_d = wdata;
			end else begin
				top_lo_d = wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rmth_pkg::S_IDLE;
			ovf_q       <= 1'b0;
			lo_cnt_q    <= '0;
			hi_cnt_q    <= '0;
			cur_med_q   <= '0;
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else begin
			state_q     <= state_d;
			ovf_q       <= ovf_d;
			lo_cnt_q    <= lo_cnt_d;
			hi_cnt_q    <= hi_cnt_d;
			cur_med_q   <= cur_med_d;
			out_valid_q <= out_valid_d;
			sel_q       <= sel_d;
		end
	end

	always_ff @(posedge clk) begin
		v_q        <= v_d;
		pv_q       <= pv_d;
		bval_q     <= bval_d;
		i_q        <= i_d;
		p_q        <= p_d;
		n_q        <= n_d;
		best_l_q   <= best_l_d;
		r_ok_q     <= r_ok_d;
		top_lo_q   <= top_lo_d;
		top_hi_q   <= top_hi_d;
		overflow_q <= overflow_d;
		median_q   <= median_d;
	end

	// heaps stay balanced between items
	a_balance: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rmth_pkg::S_IDLE |->
			({1'b0, lo_cnt_q} <= {1'b0, hi_cnt_q} + 1'b1) &&
			({1'b0, hi_cnt_q} <= {1'b0, lo_cnt_q} + 1'b1))
		else $error("heap counts out of balance");

	// store never holds more than the limit
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		total <= MAXV)
		else $error("sample count above limit");

	// lower half never ranks above upper half
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rmth_pkg::S_IDLE && lo_cnt_q != '0 && hi_cnt_q != '0) |->
			top_lo_q <= top_hi_q)
		else $error("heap tops out of order");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the running median core
// Drives sample beats in random bursts, predicts each median with a local
// two-heap model and compares every output beat in order.
// ----------------------------------------------------------------------------
module testbench;

	localparam int N_MAX   = rmth_pkg::MAX_ITEMS_DEF;
	localparam int SW      = rmth_pkg::SAMPLE_WIDTH_DEF;
	localparam int DEPTH   = N_MAX / 2 + 1;
	localparam int LIMIT   = 2000000;

	typedef struct packed {
		logic signed [SW-1:0] smp;
		logic                 rst;
	} sample_beat_t;

	typedef struct packed {
		logic signed [SW-1:0] med;
		logic                 ovf;
	} median_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SW-1:0] sample = '0;
	logic restart = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SW-1:0] median;
	logic overflow;

	running_median_two_heaps_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample(sample), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall),
		.median(median), .overflow(overflow)
	);

	always #6 clk = ~clk;

	// ---------------- median predictor ----------------
	longint lo_h[DEPTH];
	longint hi_h[DEPTH];
	int     lo_n, hi_n;
	longint cur_med;

	// max-heap when is_max, else min-heap
	function automatic bit outranks(bit is_max, longint a, longint b);
		return is_max ? (a > b) : (a < b);
	endfunction

	task automatic heap_push(bit is_max, longint v);
		int i, p;
		longint t;
		i = is_max ? lo_n : hi_n;
		if (i >= DEPTH) return;
		if (is_max) begin lo_h[i] = v; lo_n++; end
		else begin hi_h[i] = v; hi_n++; end
		while (i > 0) begin
			p = (i - 1) / 2;
			if (is_max) begin
				if (!outranks(1, lo_h[i], lo_h[p])) break;
				t = lo_h[i]; lo_h[i] = lo_h[p]; lo_h[p] = t;
			end else begin
				if (!outranks(0, hi_h[i], hi_h[p])) break;
				t = hi_h[i]; hi_h[i] = hi_h[p]; hi_h[p] = t;
			end
			i = p;
		end
	endtask

	task automatic heap_pop(bit is_max, output longint top);
		int n, i, l, r, b;
		longint t;
		n = is_max ? lo_n : hi_n;
		top = 0;
		if (n == 0) return;
		n--;
		i = 0;
		if (is_max) begin top = lo_h[0]; lo_n = n; lo_h[0] = lo_h[n]; end
		else begin top = hi_h[0]; hi_n = n; hi_h[0] = hi_h[n]; end
		forever begin
			l = 2 * i + 1; r = l + 1; b = i;
			if (is_max) begin
				if (l < n && lo_h[l] > lo_h[b]) b = l;
				if (r < n && lo_h[r] > lo_h[b]) b = r;
				if (b == i) break;
				t = lo_h[i]; lo_h[i] = lo_h[b]; lo_h[b] = t;
			end else begin
				if (l < n && hi_h[l] < hi_h[b]) b = l;
				if (r < n && hi_h[r] < hi_h[b]) b = r;
				if (b == i) break;
				t = hi_h[i]; hi_h[i] = hi_h[b]; hi_h[b] = t;
			end
			i = b;
		end
	endtask

	task automatic predict_median(sample_beat_t b, output median_beat_t r);
		longint d, m, s;
		d = longint'(b.smp);
		r.ovf = 1'b0;
		if (b.rst) begin
			lo_n = 0; hi_n = 0;
			heap_push(1, d);
			cur_med = d;
		end else if (lo_n + hi_n >= N_MAX) begin
			r.ovf = 1'b1;
		end else if (lo_n > hi_n) begin
			if (d < cur_med) begin
				heap_pop(1, m); heap_push(0, m); heap_push(1, d);
			end else heap_push(0, d);
			s = lo_h[0] + hi_h[0];
			cur_med = s / 2;   // truncates toward zero
		end else if (lo_n == hi_n) begin
			if (d < cur_med) begin heap_push(1, d); cur_med = lo_h[0]; end
			else begin heap_push(0, d); cur_med = hi_h[0]; end
		end else begin
			if (d > cur_med) begin
				heap_pop(0, m); heap_push(1, m); heap_push(0, d);
			end else heap_push(1, d);
			s = lo_h[0] + hi_h[0];
			cur_med = s / 2;
		end
		r.med = cur_med[SW-1:0];
	endtask

	// ---------------- stimulus queue ----------------
	sample_beat_t pending_q[$];
	median_beat_t expected_q[$];
	int  errors = 0;
	int  n_sent = 0, n_recv = 0, n_ovf = 0;
	bit  hold_for_drain = 1'b0;
	bit  stim_done = 1'b0;

	function automatic sample_beat_t mk(logic signed [SW-1:0] v, logic rs);
		sample_beat_t b;
		b.smp = v; b.rst = rs;
		return b;
	endfunction

	task automatic queue_beat(sample_beat_t b);
		pending_q = {pending_q, b};
	endtask

	function automatic logic signed [SW-1:0] rnd_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return SW'(int'($urandom_range(0, 15)) - 8);
			default: return SW'($urandom());
		endcase
	endfunction

	// ---------------- driver ----------------
	int burst_left = 0, gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) n_sent++;
			if (in_valid && in_stall) begin
				// beat held until taken
			end else if (hold_for_drain && expected_q.size() != 0) begin
				in_valid <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_q.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				sample_beat_t b;
				median_beat_t r;
				b = pending_q.pop_front();
				sample <= b.smp;
				restart <= b.rst;
				in_valid <= 1'b1;
				predict_median(b, r);
				expected_q = {expected_q, r};
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
				end else burst_left--;
			end
		end
	end

	// ---------------- monitor ----------------
	int stall_phase = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				median_beat_t got;
				got.med = median; got.ovf = overflow;
				n_recv++;
				if (got.ovf) n_ovf++;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected beat med=%0d ovf=%0b", $time, got.med, got.ovf);
					errors++;
				end else begin
					median_beat_t e;
					e = expected_q.pop_front();
					if (e.med !== got.med) begin
						$display("%0t: median exp=%0d got=%0d", $time, e.med, got.med);
						errors++;
					end
					if (e.ovf !== got.ovf) begin
						$display("%0t: overflow exp=%0b got=%0b", $time, e.ovf, got.ovf);
						errors++;
					end
				end
			end
			// stall pattern: calm stretches alternate with choppy ones
			stall_phase = (stall_phase + 1) % 600;
			if (stall_phase < 200) out_stall <= 1'b0;
			else if (stall_phase < 400) out_stall <= ($urandom_range(0, 2) == 0);
			else out_stall <= ($urandom_range(0, 9) == 0) ? 1'b1 : ($urandom_range(0, 30) == 0);
		end
	end

	// ---------------- cycle watchdog ----------------
	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// ---------------- sequence ----------------
	initial begin
		int k;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: no restart after reset, negative first sample
		queue_beat(mk(-16'sd5, 1'b0));
		queue_beat(mk(16'sd7, 1'b0));
		queue_beat(mk(16'sd1, 1'b0));   // tie with median
		queue_beat(mk(16'sh7fff, 1'b0));
		queue_beat(mk(16'sh8000, 1'b0));
		queue_beat(mk(16'sh8000, 1'b1)); // restart at extreme
		queue_beat(mk(16'sh8000, 1'b0));
		queue_beat(mk(16'sh7fff, 1'b0));
		queue_beat(mk(-16'sd3, 1'b1));
		queue_beat(mk(16'sd0, 1'b0));    // mean -3/2 -> -1
		queue_beat(mk(16'sh7fff, 1'b1));
		queue_beat(mk(16'sh7fff, 1'b0));
		queue_beat(mk(16'sd4, 1'b0));
		queue_beat(mk(16'sd4, 1'b0));

		// random: short sequences with restarts
		for (k = 0; k < 8; k++)
			queue_beat(mk(rnd_sample(), $urandom_range(0, 3) == 0));
		wait (pending_q.size() == 0);

		// drain pause, then fill the store to overflow
		hold_for_drain = 1'b1;
		wait (expected_q.size() == 0 && !in_valid);
		hold_for_drain = 1'b0;
		queue_beat(mk(rnd_sample(), 1'b1));
		for (k = 0; k < N_MAX + 1; k++)
			queue_beat(mk(rnd_sample(), 1'b0));
		queue_beat(mk(16'sd1, 1'b1));    // restart while full
		for (k = 0; k < 6; k++)
			queue_beat(mk(rnd_sample(), $urandom_range(0, 3) == 0));
		wait (pending_q.size() == 0 && !in_valid);
		wait (expected_q.size() == 0);
		repeat (100) @(posedge clk);

		$display("testbench: %0d beats in, %0d out, %0d overflow drops", n_sent, n_recv, n_ovf);
		$display("testbench: covered extremes, ties, restarts, full store");
		if (errors == 0 && expected_q.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
